// ----- sv/rgb2ycc_pkg.sv -----
// Shared types and constants of the RGB to YCbCr 4:2:0 converter.
`default_nettype none
package rgb2ycc_pkg;

    // Field and register widths
    localparam int CFG_W        = 13;
    localparam int SIZE_W       = 14;
    localparam int ROW_W        = 12;
    localparam int SUM_W        = 9;
    localparam int LINE_ENTRY_W = 3 * SUM_W;
    localparam int MAX_HEIGHT   = 4096;

    // Register reset values
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    // Luma weights and bias (rounding plus 16 << 13)
    localparam logic [12:0] Y_R    = 13'd2104;
    localparam logic [12:0] Y_G    = 13'd4130;
    localparam logic [12:0] Y_B    = 13'd802;
    localparam logic [20:0] Y_BIAS = 21'd135168;

    // Chroma weights and bias (rounding plus 128 << 13)
    localparam logic [12:0] CB_R   = 13'd1214;
    localparam logic [12:0] CB_G   = 13'd2384;
    localparam logic [12:0] CB_B   = 13'd3598;
    localparam logic [12:0] CR_R   = 13'd3598;
    localparam logic [12:0] CR_G   = 13'd3013;
    localparam logic [12:0] CR_B   = 13'd585;
    localparam logic [22:0] C_BIAS = 23'd1052672;

    // Output limits
    localparam logic [7:0] LUMA_MAX   = 8'd235;
    localparam logic [7:0] CHROMA_MIN = 8'd16;
    localparam logic [7:0] CHROMA_MAX = 8'd240;

    // Configuration register indexes
    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    // Classified pixel as it leaves the front end
    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
        logic             odd_col;
        logic             odd_row;
        logic             end_of_frame;
    } t_pixel_item;

    // Pixel joined with the pair sums read from the line store
    typedef struct packed {
        t_pixel_item             pixel;
        logic [LINE_ENTRY_W-1:0] line_entry;
    } t_work_item;

    // One result item
    typedef struct packed {
        logic [7:0] luma;
        logic       chroma_valid;
        logic [7:0] blue_diff;
        logic [7:0] red_diff;
        logic       end_of_frame;
    } t_result;

endpackage
`default_nettype wire

// ----- sv/rgb2ycc_ram.sv -----
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module rgb2ycc_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- sv/rgb2ycc_queue.sv -----
// Two-entry queue used between the pipeline parts and at the result side.
`default_nettype none
module rgb2ycc_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- sv/rgb2ycc_front.sv -----
// Front end: pixel accept, position tracking, pair sums and line store access.
`default_nettype none
module rgb2ycc_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire rgb2ycc_pkg::t_cfg_index        i_cfg_index,
    input  wire logic [rgb2ycc_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic                           i_push,
    output logic                                o_full,
    input  wire logic [7:0]                     i_red,
    input  wire logic [7:0]                     i_green,
    input  wire logic [7:0]                     i_blue,
    output logic                                o_push,
    output rgb2ycc_pkg::t_work_item             o_item,
    input  wire logic                           i_queue_full
);

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int SW         = rgb2ycc_pkg::SIZE_W;

    logic [rgb2ycc_pkg::CFG_W-1:0]        r_frame_width;
    logic [rgb2ycc_pkg::CFG_W-1:0]        r_frame_height;
    logic [COL_W-1:0]                     r_col;
    logic [rgb2ycc_pkg::ROW_W-1:0]        r_row;
    logic [23:0]                          r_held;
    rgb2ycc_pkg::t_pixel_item             r_s1;
    rgb2ycc_pkg::t_pixel_item             n_s1;
    logic                                 r_s1_valid;
    logic [rgb2ycc_pkg::LINE_ENTRY_W-1:0] line_rdata;

    logic [SW-1:0] width_eff;
    logic [SW-1:0] height_eff;
    logic          last_col;
    logic          last_row;
    logic          accept;
    logic          line_we;
    logic          line_re;

    // Stall only when the staged pixel cannot move on
    assign o_full = r_s1_valid && i_queue_full;
    assign accept = i_push && !o_full;

    // Effective frame size: drop the low bit, zero acts as two, saturate
    always_comb begin
        width_eff = {1'b0, r_frame_width[rgb2ycc_pkg::CFG_W-1:1], 1'b0};
        if (width_eff == '0) begin
            width_eff = SW'(2);
        end else if (width_eff > SW'(MAX_WIDTH)) begin
            width_eff = SW'(MAX_WIDTH);
        end
        height_eff = {1'b0, r_frame_height[rgb2ycc_pkg::CFG_W-1:1], 1'b0};
        if (height_eff == '0) begin
            height_eff = SW'(2);
        end else if (height_eff > SW'(rgb2ycc_pkg::MAX_HEIGHT)) begin
            height_eff = SW'(rgb2ycc_pkg::MAX_HEIGHT);
        end
    end

    assign last_col = SW'(r_col) >= (width_eff - SW'(1));
    assign last_row = SW'(r_row) >= (height_eff - SW'(1));

    // Classify the pixel and form horizontal pair sums
    always_comb begin
        n_s1.red          = i_red;
        n_s1.green        = i_green;
        n_s1.blue         = i_blue;
        n_s1.sum_red      = 9'(r_held[23:16]) + 9'(i_red);
        n_s1.sum_green    = 9'(r_held[15:8]) + 9'(i_green);
        n_s1.sum_blue     = 9'(r_held[7:0]) + 9'(i_blue);
        n_s1.odd_col      = r_col[0];
        n_s1.odd_row      = r_row[0];
        n_s1.end_of_frame = last_col && last_row;
    end

    // Even rows store pair sums, odd rows fetch them
    assign line_we = accept && r_col[0] && !r_row[0];
    assign line_re = accept && r_col[0] && r_row[0];

    rgb2ycc_ram #(
        .WIDTH (rgb2ycc_pkg::LINE_ENTRY_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (r_col[COL_W-1:1]),
        .i_wdata ({n_s1.sum_red, n_s1.sum_green, n_s1.sum_blue}),
        .i_re    (line_re),
        .i_raddr (r_col[COL_W-1:1]),
        .o_rdata (line_rdata)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= rgb2ycc_pkg::WIDTH_RESET;
            r_frame_height <= rgb2ycc_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rgb2ycc_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                rgb2ycc_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance position, hold the even-column pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else if (accept) begin
            if (!r_col[0]) begin
                r_held <= {i_red, i_green, i_blue};
            end
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Staging register, paired with the line store read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (!i_queue_full) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_push            = r_s1_valid;
    assign o_item.pixel      = r_s1;
    assign o_item.line_entry = line_rdata;

    // A stalled staged pixel and its fetched line entry hold
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && i_queue_full |=> r_s1_valid && $stable(r_s1) && $stable(line_rdata))
        else $error("staged pixel changed while stalled");

    // The line store is never written and read in one cycle
    a_line_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(line_we && line_re))
        else $error("line store written and read together");

endmodule
`default_nettype wire

// ----- sv/rgb2ycc_back.sv -----
// Back end: luma and 2x2 chroma arithmetic in two registered stages.
`default_nettype none
module rgb2ycc_back (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire rgb2ycc_pkg::t_work_item i_item,
    output logic                         o_take,
    output logic                         o_push,
    output rgb2ycc_pkg::t_result         o_result,
    input  wire logic                    i_full
);

    // Stage one contents
    typedef struct packed {
        logic [7:0] luma;
        logic       chroma_valid;
        logic [7:0] avg_red;
        logic [7:0] avg_green;
        logic [7:0] avg_blue;
        logic       end_of_frame;
    } t_stage1;

    t_stage1              r_b1;
    t_stage1              n_b1;
    logic                 r_b1_valid;
    rgb2ycc_pkg::t_result r_b2;
    rgb2ycc_pkg::t_result n_b2;
    logic                 r_b2_valid;
    logic                 b1_ready;
    logic                 b2_ready;

    logic [20:0] luma_sum;
    logic [9:0]  quad_red;
    logic [9:0]  quad_green;
    logic [9:0]  quad_blue;
    logic [22:0] cb_sum;
    logic [22:0] cr_sum;
    logic [9:0]  cb_q;
    logic [9:0]  cr_q;

    assign b2_ready = !r_b2_valid || !i_full;
    assign b1_ready = !r_b1_valid || b2_ready;
    assign o_take   = i_valid && b1_ready;
    assign o_push   = r_b2_valid;
    assign o_result = r_b2;

    // Stage one: luma and rounded 2x2 averages
    always_comb begin
        luma_sum = 21'(i_item.pixel.red) * rgb2ycc_pkg::Y_R
                 + 21'(i_item.pixel.green) * rgb2ycc_pkg::Y_G
                 + 21'(i_item.pixel.blue) * rgb2ycc_pkg::Y_B
                 + rgb2ycc_pkg::Y_BIAS;
        quad_red   = 10'(i_item.pixel.sum_red) + 10'(i_item.line_entry[26:18]) + 10'd2;
        quad_green = 10'(i_item.pixel.sum_green) + 10'(i_item.line_entry[17:9]) + 10'd2;
        quad_blue  = 10'(i_item.pixel.sum_blue) + 10'(i_item.line_entry[8:0]) + 10'd2;
        n_b1.luma = (luma_sum[20:13] > rgb2ycc_pkg::LUMA_MAX) ? rgb2ycc_pkg::LUMA_MAX
                                                               : luma_sum[20:13];
        n_b1.chroma_valid = i_item.pixel.odd_col && i_item.pixel.odd_row;
        n_b1.avg_red      = quad_red[9:2];
        n_b1.avg_green    = quad_green[9:2];
        n_b1.avg_blue     = quad_blue[9:2];
        n_b1.end_of_frame = i_item.pixel.end_of_frame;
    end

    // Stage two: chroma products, scale and clamp; the sums stay positive
    always_comb begin
        cb_sum = 23'(r_b1.avg_blue) * rgb2ycc_pkg::CB_B + rgb2ycc_pkg::C_BIAS
               - 23'(r_b1.avg_red) * rgb2ycc_pkg::CB_R
               - 23'(r_b1.avg_green) * rgb2ycc_pkg::CB_G;
        cr_sum = 23'(r_b1.avg_red) * rgb2ycc_pkg::CR_R + rgb2ycc_pkg::C_BIAS
               - 23'(r_b1.avg_green) * rgb2ycc_pkg::CR_G
               - 23'(r_b1.avg_blue) * rgb2ycc_pkg::CR_B;
        cb_q = cb_sum[22:13];
        cr_q = cr_sum[22:13];
        n_b2.luma         = r_b1.luma;
        n_b2.chroma_valid = r_b1.chroma_valid;
        n_b2.end_of_frame = r_b1.end_of_frame;
        if (!r_b1.chroma_valid) begin
            n_b2.blue_diff = '0;
            n_b2.red_diff  = '0;
        end else begin
            if (cb_q < 10'(rgb2ycc_pkg::CHROMA_MIN)) begin
                n_b2.blue_diff = rgb2ycc_pkg::CHROMA_MIN;
            end else if (cb_q > 10'(rgb2ycc_pkg::CHROMA_MAX)) begin
                n_b2.blue_diff = rgb2ycc_pkg::CHROMA_MAX;
            end else begin
                n_b2.blue_diff = cb_q[7:0];
            end
            if (cr_q < 10'(rgb2ycc_pkg::CHROMA_MIN)) begin
                n_b2.red_diff = rgb2ycc_pkg::CHROMA_MIN;
            end else if (cr_q > 10'(rgb2ycc_pkg::CHROMA_MAX)) begin
                n_b2.red_diff = rgb2ycc_pkg::CHROMA_MAX;
            end else begin
                n_b2.red_diff = cr_q[7:0];
            end
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
        end else begin
            if (b1_ready) begin
                r_b1_valid <= i_valid;
            end
            if (b2_ready) begin
                r_b2_valid <= r_b1_valid;
            end
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_b1 <= n_b1;
        end
        if (b2_ready && r_b1_valid) begin
            r_b2 <= n_b2;
        end
    end

    // A result stalled by the output queue holds
    a_b2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b2_valid && i_full |=> r_b2_valid && $stable(r_b2))
        else $error("result changed while stalled");

    // Luma stays within studio range
    a_luma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b2_valid |-> r_b2.luma >= 8'd16 && r_b2.luma <= rgb2ycc_pkg::LUMA_MAX)
        else $error("luma out of range");

    // Valid chroma is clamped, missing chroma is zero
    a_chroma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b2_valid && r_b2.chroma_valid |->
            r_b2.blue_diff >= rgb2ycc_pkg::CHROMA_MIN &&
            r_b2.blue_diff <= rgb2ycc_pkg::CHROMA_MAX &&
            r_b2.red_diff >= rgb2ycc_pkg::CHROMA_MIN &&
            r_b2.red_diff <= rgb2ycc_pkg::CHROMA_MAX)
        else $error("chroma out of range");

    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b2_valid && !r_b2.chroma_valid |-> r_b2.blue_diff == '0 && r_b2.red_diff == '0)
        else $error("chroma not zero on a pixel without a block");

endmodule
`default_nettype wire

// ----- sv/rgb_to_ycbcr420_converter.sv -----
// Top level of the RGB to YCbCr 4:2:0 converter.
//
//  channel   handshake          payload
//  -------   ---------          -------
//  pixel in  push / full        i_red, i_green, i_blue
//  result    empty / pop        o_luma, o_chroma_valid, o_blue_diff, o_red_diff,
//                               o_end_of_frame
//  config    i_cfg_we           i_cfg_index, i_cfg_data (frame_width, frame_height)
//
// One pixel per clock sustained while results are popped; a result passes the
// staging register and line store read, the work queue, two arithmetic stages
// and the result queue before it shows on the result ports. Each pixel makes at
// most one line store access, a write on even rows or a read on odd rows at its
// odd column, so nothing holds the rate below one per clock. Reset clears all
// control state; the line store holds no reset value and needs no clearing
// pass. A stall at the result side backs up through the queues to full
// without losing a transfer; a full queue takes no push in the cycle it pops.
`default_nettype none
module rgb_to_ycbcr420_converter #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire rgb2ycc_pkg::t_cfg_index       i_cfg_index,
    input  wire logic [rgb2ycc_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [7:0]                    i_red,
    input  wire logic [7:0]                    i_green,
    input  wire logic [7:0]                    i_blue,
    output logic                               empty,
    input  wire logic                          pop,
    output logic      [7:0]                    o_luma,
    output logic                               o_chroma_valid,
    output logic      [7:0]                    o_blue_diff,
    output logic      [7:0]                    o_red_diff,
    output logic                               o_end_of_frame
);

    rgb2ycc_pkg::t_work_item front_item;
    rgb2ycc_pkg::t_work_item work_item;
    rgb2ycc_pkg::t_result    back_result;
    rgb2ycc_pkg::t_result    out_result;
    logic                    front_push;
    logic                    work_full;
    logic                    work_empty;
    logic                    back_take;
    logic                    back_push;
    logic                    out_full;

    // Accept and classify pixels
    rgb2ycc_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .o_full       (full),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_push       (front_push),
        .o_item       (front_item),
        .i_queue_full (work_full)
    );

    // Decouple front and back
    rgb2ycc_queue #(
        .WIDTH ($bits(rgb2ycc_pkg::t_work_item))
    ) u_work_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_item),
        .o_full  (work_full),
        .i_pop   (back_take),
        .o_data  (work_item),
        .o_empty (work_empty)
    );

    // Compute luma and chroma
    rgb2ycc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!work_empty),
        .i_item   (work_item),
        .o_take   (back_take),
        .o_push   (back_push),
        .o_result (back_result),
        .i_full   (out_full)
    );

    // Hold results for the consumer
    rgb2ycc_queue #(
        .WIDTH ($bits(rgb2ycc_pkg::t_result))
    ) u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_push),
        .i_data  (back_result),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_result),
        .o_empty (empty)
    );

    assign o_luma         = out_result.luma;
    assign o_chroma_valid = out_result.chroma_valid;
    assign o_blue_diff    = out_result.blue_diff;
    assign o_red_diff     = out_result.red_diff;
    assign o_end_of_frame = out_result.end_of_frame;

endmodule
`default_nettype wire

// ----- bench/rgb_to_ycbcr420_converter_tb.sv -----
// Self-checking testbench for the RGB to YCbCr 4:2:0 converter.
module rgb_to_ycbcr420_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W       = 4096;
    localparam int MAX_H       = 4096;
    localparam int LINE_SLOTS  = MAX_W / 2;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int DRAIN_WAIT  = 20;
    localparam int CFG_BITS    = rgb2ycc_pkg::CFG_W;
    localparam int ENTRY_BITS  = rgb2ycc_pkg::LINE_ENTRY_W;

    // Fixed-point weights, 13 fractional bits
    localparam int Y_WR     = 2104;
    localparam int Y_WG     = 4130;
    localparam int Y_WB     = 802;
    localparam int Y_OFFSET = 4096 + 131072;
    localparam int CB_WR    = -1214;
    localparam int CB_WG    = -2384;
    localparam int CB_WB    = 3598;
    localparam int CR_WR    = 3598;
    localparam int CR_WG    = -3013;
    localparam int CR_WB    = -585;
    localparam int C_OFFSET = 4096 + 1048576;
    localparam int Y_TOP    = 235;
    localparam int C_BOTTOM = 16;
    localparam int C_TOP    = 240;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    rgb2ycc_pkg::t_cfg_index i_cfg_index = rgb2ycc_pkg::CFG_FRAME_WIDTH;
    logic [CFG_BITS-1:0]     i_cfg_data  = '0;
    logic                    push        = 1'b0;
    logic                    full;
    logic [7:0]              i_red       = '0;
    logic [7:0]              i_green     = '0;
    logic [7:0]              i_blue      = '0;
    logic                    empty;
    logic                    pop         = 1'b0;
    logic [7:0]              o_luma;
    logic                    o_chroma_valid;
    logic [7:0]              o_blue_diff;
    logic [7:0]              o_red_diff;
    logic                    o_end_of_frame;

    // Predictor state
    logic [CFG_BITS-1:0]   width_reg  = rgb2ycc_pkg::WIDTH_RESET;
    logic [CFG_BITS-1:0]   height_reg = rgb2ycc_pkg::HEIGHT_RESET;
    logic [ENTRY_BITS-1:0] pair_sums [LINE_SLOTS];
    logic [23:0]           held_rgb   = '0;
    int                    col_pos    = 0;
    int                    row_pos    = 0;

    rgb2ycc_pkg::t_result pending_ycc [$];
    int                   mismatch_count = 0;
    int                   report_count   = 0;
    int                   cycle_count    = 0;
    int                   sink_stall     = 0;
    logic                 steady         = 1'b0;

    rgb_to_ycbcr420_converter i_dut (.*);

    always #4 i_clk = ~i_clk;

    // Short gaps mostly, a few long ones; none during steady stretches
    function automatic int idle_gap();
        int p;
        if (steady) return 0;
        p = $urandom_range(0, 99);
        if (p < 70) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int eff_size(logic [CFG_BITS-1:0] v, int limit);
        int s;
        s = int'(v) & 'h1FFE;
        if (s == 0) s = 2;
        if (s > limit) s = limit;
        return s;
    endfunction

    function automatic logic [7:0] clamp_chroma(int v);
        if (v < C_BOTTOM) return 8'(C_BOTTOM);
        if (v > C_TOP) return 8'(C_TOP);
        return 8'(v);
    endfunction

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Work out the result of one pixel and advance the raster position
    task automatic convert_pixel(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b);
        int w, h, slot, y, sr, sg, sb, ar, ag, ab;
        logic last_col, last_row;
        logic [ENTRY_BITS-1:0] entry;
        rgb2ycc_pkg::t_result res;
        w = eff_size(width_reg, MAX_W);
        h = eff_size(height_reg, MAX_H);
        last_col = (col_pos >= w - 1);
        last_row = (row_pos >= h - 1);
        slot = (col_pos >> 1) % LINE_SLOTS;
        res = '0;
        y = (int'(r) * Y_WR + int'(g) * Y_WG + int'(b) * Y_WB + Y_OFFSET) >> 13;
        if (y > Y_TOP) y = Y_TOP;
        res.luma = 8'(y);
        if (col_pos % 2 == 0) begin
            held_rgb = {r, g, b};
        end else begin
            sr = int'(held_rgb[23:16]) + int'(r);
            sg = int'(held_rgb[15:8]) + int'(g);
            sb = int'(held_rgb[7:0]) + int'(b);
            if (row_pos % 2 == 0) begin
                pair_sums[slot] = {9'(sr), 9'(sg), 9'(sb)};
            end else begin
                entry = pair_sums[slot];
                ar = (sr + int'(entry[26:18]) + 2) >> 2;
                ag = (sg + int'(entry[17:9]) + 2) >> 2;
                ab = (sb + int'(entry[8:0]) + 2) >> 2;
                res.blue_diff = clamp_chroma(
                    (CB_WR * ar + CB_WG * ag + CB_WB * ab + C_OFFSET) / 8192);
                res.red_diff = clamp_chroma(
                    (CR_WR * ar + CR_WG * ag + CR_WB * ab + C_OFFSET) / 8192);
                res.chroma_valid = 1'b1;
            end
        end
        res.end_of_frame = last_col && last_row;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        pending_ycc.push_back(res);
    endtask

    // Offer one pixel and hold it until transfer
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push    <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        do @(posedge i_clk); while (full);
        convert_pixel(r, g, b);
    endtask

    task automatic send_random(input int n);
        repeat (n) send_pixel(pick_level(), pick_level(), pick_level());
    endtask

    // Write a register once every outstanding result has been taken
    task automatic write_reg(input rgb2ycc_pkg::t_cfg_index idx,
                             input logic [CFG_BITS-1:0] value);
        push <= 1'b0;
        while (pending_ycc.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        if (idx == rgb2ycc_pkg::CFG_FRAME_WIDTH) width_reg = value;
        else height_reg = value;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
        write_reg(rgb2ycc_pkg::CFG_FRAME_WIDTH, w);
        write_reg(rgb2ycc_pkg::CFG_FRAME_HEIGHT, h);
    endtask

    // One row and the first block of the next at the reset size, then close
    // the frame with zero and odd sizes
    task automatic test_reset_size();
        send_random(640 + 2);
        set_frame(13'd0, 13'd1);
        send_random(1);
    endtask

    // Black, white, primaries and alternating bit patterns
    task automatic test_extreme_pixels();
        logic [23:0] pats [24];
        pats = '{24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
                 24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
                 24'h0000FF, 24'h0000FF, 24'hFF0000, 24'hFF0000,
                 24'h0000FF, 24'h0000FF, 24'hFF0000, 24'hFF0000,
                 24'h00FF00, 24'h00FF00, 24'h55AA55, 24'hAA55AA,
                 24'h00FF00, 24'hFF00FF, 24'h55AA55, 24'hAA55AA};
        set_frame(13'd4, 13'd2);
        foreach (pats[i]) send_pixel(pats[i][23:16], pats[i][15:8], pats[i][7:0]);
    endtask

    // Width register beyond the line store, then shrink to close the frame
    task automatic test_width_limit();
        set_frame(13'h1FFF, 13'd2);
        send_random(64);
        set_frame(13'd2, 13'd2);
        send_random(3);
    endtask

    // Height register beyond the limit, then shrink to close the frame
    task automatic test_height_limit();
        set_frame(13'd2, 13'h1FFF);
        send_random(40);
        write_reg(rgb2ycc_pkg::CFG_FRAME_HEIGHT, 13'd2);
        send_random(2);
    endtask

    task automatic test_odd_sizes();
        set_frame(13'd7, 13'd5);
        send_random(6 * 4);
    endtask

    // Shrink height, shrink width and widen while a frame is in progress
    task automatic test_midframe_resize();
        set_frame(13'd8, 13'd8);
        send_random(3 * 8 + 5);
        write_reg(rgb2ycc_pkg::CFG_FRAME_HEIGHT, 13'd2);
        send_random(3);
        send_random(8 + 5);
        write_reg(rgb2ycc_pkg::CFG_FRAME_WIDTH, 13'd4);
        send_random(1);
        send_random(3);
        write_reg(rgb2ycc_pkg::CFG_FRAME_WIDTH, 13'd12);
        send_random(9 + 12);
    endtask

    // Mostly whole small frames, some cut short before the next resize
    task automatic test_random_frames();
        int sent, n;
        logic [CFG_BITS-1:0] w, h;
        sent = 0;
        while (sent < 350) begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) w = CFG_BITS'($urandom_range(0, 64));
            else w = CFG_BITS'($urandom_range(0, 17));
            h = CFG_BITS'($urandom_range(0, 9));
            set_frame(w, h);
            n = eff_size(w, MAX_W) * eff_size(h, MAX_H);
            if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
            send_random(n);
            sent += n;
        end
        steady = 1'b0;
    endtask

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (report_count < 200) begin
                report_count++;
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            end
        end
    endtask

    // Check each result transfer and pace the pop side
    always @(posedge i_clk) begin : result_check
        rgb2ycc_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_ycc.size() == 0) begin
                mismatch_count++;
                if (report_count < 200) begin
                    report_count++;
                    $display("%0t: result expected none actual luma %0d", $time, o_luma);
                end
            end else begin
                want = pending_ycc.pop_front();
                compare_field("luma", want.luma, o_luma);
                compare_field("chroma_valid", 8'(want.chroma_valid), 8'(o_chroma_valid));
                compare_field("blue_diff", want.blue_diff, o_blue_diff);
                compare_field("red_diff", want.red_diff, o_red_diff);
                compare_field("end_of_frame", 8'(want.end_of_frame), 8'(o_end_of_frame));
            end
        end
        if (sink_stall > 0) begin
            pop <= 1'b0;
            sink_stall--;
        end else begin
            pop <= 1'b1;
            sink_stall = idle_gap();
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rgb_to_ycbcr420_converter_tb failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_size();
        test_extreme_pixels();
        test_width_limit();
        test_height_limit();
        test_odd_sizes();
        test_midframe_resize();
        test_random_frames();
        // Drain and watch for stray results
        push <= 1'b0;
        while (pending_ycc.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("rgb_to_ycbcr420_converter_tb passed");
        else
            $display("rgb_to_ycbcr420_converter_tb failed");
        $finish;
    end

endmodule
